// ===== sv/btas_pkg.sv =====
`default_nettype none

package btas_pkg;

   // Field widths
   localparam int unsigned COUNT_W = 10;
   localparam int unsigned MV_W    = 16;
   localparam int unsigned CODE_W  = 8;
   localparam int unsigned PCT_W   = 7;
   localparam int unsigned CSR_W   = 16;
   localparam int unsigned CSR_IDX_W = 2;

   // Supply conversion: mV = BANDGAP_MV * ADC_FULL_SCALE / count
   localparam int unsigned ADC_FULL_SCALE = 1023;
   localparam int unsigned BANDGAP_MV     = 1100;
   localparam int unsigned DIVIDEND       = BANDGAP_MV * ADC_FULL_SCALE;
   // Low 16 dividend bits feed the 16 quotient steps
   localparam logic [15:0] DIVIDEND_LO = 16'(DIVIDEND % 65536);
   // Counts at or below this overflow 16 bits; also the starting remainder
   localparam logic [COUNT_W-1:0] SAT_LIMIT = COUNT_W'(DIVIDEND / 65536);

   // Voltage code: (mV - 1000) / 10, divide by 10 as multiply by 52429 >> 19
   localparam logic [MV_W-1:0] MV_OFFSET   = 16'd1000;
   localparam logic [MV_W-1:0] CODE_SAT_MV = 16'd3560;
   localparam logic [15:0]     CODE_RECIP  = 16'd52429;
   localparam int unsigned     CODE_SHIFT  = 19;

   // Temperature: (50 * count - 16205) / 61, divide as multiply by 17190 >> 20
   localparam logic [15:0] TEMP_SCALE  = 16'd50;
   localparam logic [15:0] TEMP_OFFSET = 16'd16205;
   localparam int unsigned TEMP_DIV    = 61;
   localparam logic [15:0] TEMP_SAT    = 16'(256 * TEMP_DIV);
   localparam logic [14:0] TEMP_RECIP  = 15'd17190;
   localparam int unsigned TEMP_SHIFT  = 20;

   localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

   // Pipeline depth
   localparam int unsigned NUM_STAGES = 10;

   // Register reset values
   localparam logic [MV_W-1:0]   LOW_BATT_MV_RST = 16'd2400;
   localparam logic [CODE_W-1:0] EMPTY_CODE_RST  = 8'd90;
   localparam logic [CODE_W-1:0] FULL_CODE_RST   = 8'd200;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOW_BATT_MV = 2'd0,
      CSR_EMPTY_CODE  = 2'd1,
      CSR_FULL_CODE   = 2'd2
   } csr_index_type;

   // Supply divider state
   typedef struct packed {
      logic [COUNT_W-1:0] rem;
      logic [MV_W-1:0]    q;
   } mv_div_type;

   // Percent divider state
   typedef struct packed {
      logic [CODE_W-1:0] rem;
      logic [PCT_W-1:0]  n;
      logic [PCT_W-1:0]  q;
   } pct_div_type;

   // One pipeline stage record
   typedef struct packed {
      logic [COUNT_W-1:0] bg;
      logic               sat;
      mv_div_type         div;
      logic [15:0]        ts;
      logic [13:0]        tx;
      logic               tsat;
      logic [CODE_W-1:0]  tdeg;
      logic [MV_W-1:0]    mv;
      logic               low;
      logic [11:0]        cx;
      logic               csat;
      logic [CODE_W-1:0]  code;
      logic               below;
      logic               above;
      logic               span_zero;
      logic [CODE_W-1:0]  span;
      pct_div_type        pdiv;
      logic [PCT_W-1:0]   pct;
   } stage_type;

endpackage

`default_nettype wire

// ===== sv/btas_if.sv =====
`default_nettype none

// Request channel: one pair of ADC counts per transaction
interface btas_req_if import btas_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] bandgap_count;
   logic [COUNT_W-1:0] temp_count;

   modport source (output valid, bandgap_count, temp_count, input ready);
   modport sink   (input valid, bandgap_count, temp_count, output ready);
endinterface

// Response channel: one scaled result per transaction
interface btas_rsp_if import btas_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MV_W-1:0]   supply_mv;
   logic              low_batt;
   logic [CODE_W-1:0] volt_code;
   logic [CODE_W-1:0] temp_deg;
   logic [PCT_W-1:0]  batt_percent;

   modport source (output valid, supply_mv, low_batt, volt_code, temp_deg, batt_percent,
                   input ready);
   modport sink   (input valid, supply_mv, low_batt, volt_code, temp_deg, batt_percent,
                   output ready);
endinterface

`default_nettype wire

// ===== sv/battery_temp_adc_scaler_top.sv =====
// Battery and temperature ADC scaler.
// req_ch carries one bandgap count and one temperature-sensor count per
// transaction; rsp_ch returns supply millivolts, the low-battery flag, the
// packed voltage code, degrees Celsius and battery percent for each one, in
// order. csr_* writes the low-battery threshold, empty code and full code;
// write them only while no transaction is in flight.
// Throughput: one transaction per cycle while rsp_ch is not stalled. Ten
// register stages hold the supply divider four steps at a time, the constant
// multiplies and compares, and the percent divider in steps of four and three;
// the 16-step supply division and the 7-step percent division set the depth.
// A transaction passes through every stage register in order to reach rsp_ch.
// Reset (synchronous) empties the pipeline and loads the register defaults
// (2400 mV, code 90, code 200).
// Stall: when rsp_ch.ready is low, stages fill up behind the output
// register; req_ch.ready drops only when every stage holds a transaction.
`default_nettype none

module battery_temp_adc_scaler_top import btas_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   btas_req_if.sink                  req_ch,
   btas_rsp_if.source                rsp_ch,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   logic [MV_W-1:0]   low_batt_mv_ff, low_batt_mv_in;
   logic [CODE_W-1:0] empty_code_ff, empty_code_in;
   logic [CODE_W-1:0] full_code_ff, full_code_in;

   logic [NUM_STAGES-1:0] vld_ff, vld_in, en;
   stage_type st_ff [NUM_STAGES];
   stage_type st_in [NUM_STAGES];

   logic [28:0]  tprod;
   logic [27:0]  cprod;
   logic [CODE_W-1:0] pdiff;
   logic [14:0]  pprod;

   // Four restoring steps of the supply divider
   function automatic mv_div_type mv_div_step(input mv_div_type cur,
                                              input logic [COUNT_W-1:0] divisor,
                                              input logic [3:0] bits);
      mv_div_type res;
      logic [COUNT_W:0] trial;
      res = cur;
      for (int j = 0; j < 4; j++) begin
         trial = {res.rem, bits[3-j]};
         if (trial >= {1'b0, divisor}) begin
            trial = trial - {1'b0, divisor};
            res.q = {res.q[MV_W-2:0], 1'b1};
         end else begin
            res.q = {res.q[MV_W-2:0], 1'b0};
         end
         res.rem = trial[COUNT_W-1:0];
      end
      return res;
   endfunction

   // Up to four restoring steps of the percent divider
   function automatic pct_div_type pct_div_step(input pct_div_type cur,
                                                input logic [CODE_W-1:0] divisor,
                                                input int unsigned steps);
      pct_div_type res;
      logic [CODE_W:0] trial;
      res = cur;
      for (int j = 0; j < 4; j++) begin
         if (j < steps) begin
            trial = {res.rem, res.n[PCT_W-1]};
            res.n = {res.n[PCT_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor}) begin
               trial = trial - {1'b0, divisor};
               res.q = {res.q[PCT_W-2:0], 1'b1};
            end else begin
               res.q = {res.q[PCT_W-2:0], 1'b0};
            end
            res.rem = trial[CODE_W-1:0];
         end
      end
      return res;
   endfunction

   // Configuration writes; unknown indexes drop
   always_comb begin
      low_batt_mv_in = low_batt_mv_ff;
      empty_code_in  = empty_code_ff;
      full_code_in   = full_code_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_LOW_BATT_MV: low_batt_mv_in = csr_wdata;
            CSR_EMPTY_CODE:  empty_code_in  = csr_wdata[CODE_W-1:0];
            CSR_FULL_CODE:   full_code_in   = csr_wdata[CODE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_batt_mv_ff <= LOW_BATT_MV_RST;
         empty_code_ff  <= EMPTY_CODE_RST;
         full_code_ff   <= FULL_CODE_RST;
      end else begin
         low_batt_mv_ff <= low_batt_mv_in;
         empty_code_ff  <= empty_code_in;
         full_code_ff   <= full_code_in;
      end
   end

   // Stage enables: a stage loads when empty or when its content moves on
   always_comb begin
      en[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || rsp_ch.ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
      vld_in[0] = en[0] ? req_ch.valid : vld_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         vld_in[k] = en[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   assign req_ch.ready = en[0];

   // Stage 0: capture counts, flag supply overflow, scale temperature
   always_comb begin
      st_in[0]           = '0;
      st_in[0].bg        = req_ch.bandgap_count;
      st_in[0].sat       = req_ch.bandgap_count <= SAT_LIMIT;
      st_in[0].div.rem   = SAT_LIMIT;
      st_in[0].ts        = {6'd0, req_ch.temp_count} * TEMP_SCALE;
   end

   // Stage 1: supply quotient bits 15..12, remove temperature offset
   always_comb begin
      st_in[1]     = st_ff[0];
      st_in[1].div = mv_div_step(st_ff[0].div, st_ff[0].bg, DIVIDEND_LO[15:12]);
      if (st_ff[0].ts < TEMP_OFFSET) begin
         st_in[1].tx   = '0;
         st_in[1].tsat = 1'b0;
      end else begin
         st_in[1].tx   = 14'(st_ff[0].ts - TEMP_OFFSET);
         st_in[1].tsat = (st_ff[0].ts - TEMP_OFFSET) >= TEMP_SAT;
      end
   end

   // Stage 2: quotient bits 11..8, temperature divide by reciprocal
   always_comb begin
      st_in[2]      = st_ff[1];
      st_in[2].div  = mv_div_step(st_ff[1].div, st_ff[1].bg, DIVIDEND_LO[11:8]);
      tprod         = {15'd0, st_ff[1].tx} * {14'd0, TEMP_RECIP};
      st_in[2].tdeg = st_ff[1].tsat ? '1 : tprod[TEMP_SHIFT+CODE_W-1:TEMP_SHIFT];
   end

   // Stage 3: quotient bits 7..4
   always_comb begin
      st_in[3]     = st_ff[2];
      st_in[3].div = mv_div_step(st_ff[2].div, st_ff[2].bg, DIVIDEND_LO[7:4]);
   end

   // Stage 4: quotient bits 3..0
   always_comb begin
      st_in[4]     = st_ff[3];
      st_in[4].div = mv_div_step(st_ff[3].div, st_ff[3].bg, DIVIDEND_LO[3:0]);
   end

   // Stage 5: saturate supply, compare threshold, offset for voltage code
   always_comb begin
      st_in[5]      = st_ff[4];
      st_in[5].mv   = st_ff[4].sat ? '1 : st_ff[4].div.q;
      st_in[5].low  = st_in[5].mv <= low_batt_mv_ff;
      st_in[5].csat = st_in[5].mv >= CODE_SAT_MV;
      st_in[5].cx   = (st_in[5].mv < MV_OFFSET) ? '0 : 12'(st_in[5].mv - MV_OFFSET);
   end

   // Stage 6: divide by ten through reciprocal
   always_comb begin
      st_in[6]      = st_ff[5];
      cprod         = {16'd0, st_ff[5].cx} * {12'd0, CODE_RECIP};
      st_in[6].code = st_ff[5].csat ? '1 : cprod[CODE_SHIFT+CODE_W-1:CODE_SHIFT];
   end

   // Stage 7: classify code against empty and full, scale numerator
   always_comb begin
      st_in[7]           = st_ff[6];
      st_in[7].below     = st_ff[6].code < empty_code_ff;
      st_in[7].above     = st_ff[6].code > full_code_ff;
      st_in[7].span_zero = full_code_ff == empty_code_ff;
      st_in[7].span      = full_code_ff - empty_code_ff;
      pdiff              = st_ff[6].code - empty_code_ff;
      pprod              = {7'd0, pdiff} * {8'd0, PCT_FULL};
      st_in[7].pdiv.rem  = pprod[14:PCT_W];
      st_in[7].pdiv.n    = pprod[PCT_W-1:0];
      st_in[7].pdiv.q    = '0;
   end

   // Stage 8: percent quotient bits 6..3
   always_comb begin
      st_in[8]      = st_ff[7];
      st_in[8].pdiv = pct_div_step(st_ff[7].pdiv, st_ff[7].span, 4);
   end

   // Stage 9: percent quotient bits 2..0, apply clamps
   always_comb begin
      st_in[9]      = st_ff[8];
      st_in[9].pdiv = pct_div_step(st_ff[8].pdiv, st_ff[8].span, 3);
      if (st_ff[8].below) begin
         st_in[9].pct = '0;
      end else if (st_ff[8].above || st_ff[8].span_zero) begin
         st_in[9].pct = PCT_FULL;
      end else begin
         st_in[9].pct = st_in[9].pdiv.q;
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_STAGES; k++) begin
         if (en[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   // Drive response from the last stage
   assign rsp_ch.valid        = vld_ff[NUM_STAGES-1];
   assign rsp_ch.supply_mv    = st_ff[NUM_STAGES-1].mv;
   assign rsp_ch.low_batt     = st_ff[NUM_STAGES-1].low;
   assign rsp_ch.volt_code    = st_ff[NUM_STAGES-1].code;
   assign rsp_ch.temp_deg     = st_ff[NUM_STAGES-1].tdeg;
   assign rsp_ch.batt_percent = st_ff[NUM_STAGES-1].pct;

`ifndef SYNTHESIS
   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("response valid after reset");

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.batt_percent <= PCT_FULL)
      else $error("battery percent above full");

   a_code_floor: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.supply_mv < MV_OFFSET) |-> rsp_ch.volt_code == '0)
      else $error("voltage code nonzero below offset");

   a_code_ceiling: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.supply_mv >= CODE_SAT_MV) |-> rsp_ch.volt_code == '1)
      else $error("voltage code not saturated");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      ((&vld_ff) && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("request taken into a full stalled pipeline");
`endif

endmodule

`default_nettype wire
